// ===== rtl/sip_pkg.sv =====
// Package for the self-ID packet parser: field positions, status codes,
// and the request and result types used across the parser and its checker.
// No dependencies.
package sip_pkg;

    localparam int MAX_NODES         = 63;
    localparam int MORE_PACKETS_USED = 3;
    localparam int NODE_W            = 6;

    localparam logic [1:0] SELF_ID_TAG = 2'd2;

    localparam int TAG_LO   = 30;
    localparam int ID_LO    = 24;
    localparam int MORE_BIT = 23;
    localparam int LINK_BIT = 22;
    localparam int SEQ_LO   = 20;
    localparam int SPD_LO   = 14;
    localparam int CONT_BIT = 11;
    localparam int IRST_BIT = 1;
    localparam int NEXT_BIT = 0;

    localparam logic [3:0] INIT_PORT_COUNT = 4'd3;
    localparam logic [3:0] MORE_PORT_COUNT = 4'd8;
    localparam logic [4:0] MORE_PORT_FIRST = 5'd3;

    typedef enum logic [1:0] {
        ST_INITIAL      = 2'd0,
        ST_MORE_USED    = 2'd1,
        ST_MORE_IGNORED = 2'd2,
        ST_ERROR        = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] self_id_word;
        logic        final_word;
    } t_request;

    typedef struct packed {
        t_status               status;
        logic [NODE_W-1:0]     node_id;
        logic                  link_active;
        logic                  contender;
        logic [1:0]            phy_speed;
        logic                  initiated_reset;
        logic [4:0]            port_base;
        logic [3:0]            port_count;
        logic [15:0]           port_states;
        logic [MAX_NODES-1:0]  link_mask;
        logic [MAX_NODES-1:0]  contender_mask;
        logic [NODE_W-1:0]     node_count;
    } t_result;

endpackage

// ===== rtl/self_id_packet_parser_top.sv =====
// Top level of the self-ID packet parser.
// Depends on sip_pkg, sip_in_stage, sip_check and sip_out_stage.
//
// Input channel: i_in_valid / o_in_ready carry one self-ID quadlet
// (i_self_id_word) and i_final_word, which marks the last quadlet of a map.
// Result channel: o_res_valid / i_res_ready carry one result per quadlet:
// status, node id, the fields of an initial or continuation packet, and
// the running link and contender masks with the node count.
// A request held in the input register is checked combinationally and its
// result is loaded into the result register once that register is free.
// Throughput: one quadlet per cycle while the receiver takes results, set by
// the single check stage between the input register and the result register.
// A result waiting on a stalled receiver does not block the input register
// from taking the next request; with both registers full, o_in_ready drops
// until the receiver takes the result.
// An error is sticky for the rest of the map; the final quadlet returns
// the map state to zero after its result is formed.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// map state.
module self_id_packet_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_self_id_word,
    input  logic        i_final_word,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_node_id,
    output logic        o_link_active,
    output logic        o_contender,
    output logic [1:0]  o_phy_speed,
    output logic        o_initiated_reset,
    output logic [4:0]  o_port_base,
    output logic [3:0]  o_port_count,
    output logic [15:0] o_port_states,
    output logic [62:0] o_link_mask,
    output logic [62:0] o_contender_mask,
    output logic [5:0]  o_node_count
);

    sip_pkg::t_request in_req;
    sip_pkg::t_request held_req;
    sip_pkg::t_result  chk_res;
    sip_pkg::t_result  out_res;
    logic              held_valid;
    logic              out_free;
    logic              adv;

    assign in_req.self_id_word = i_self_id_word;
    assign in_req.final_word   = i_final_word;
    assign adv = held_valid && out_free;

    sip_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_req   (in_req),
        .i_adv   (adv),
        .o_ready (o_in_ready),
        .o_valid (held_valid),
        .o_req   (held_req)
    );

    sip_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_req   (held_req),
        .o_res   (chk_res)
    );

    sip_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (chk_res),
        .i_ready (i_res_ready),
        .o_free  (out_free),
        .o_valid (o_res_valid),
        .o_res   (out_res)
    );

    assign o_status          = out_res.status;
    assign o_node_id         = out_res.node_id;
    assign o_link_active     = out_res.link_active;
    assign o_contender       = out_res.contender;
    assign o_phy_speed       = out_res.phy_speed;
    assign o_initiated_reset = out_res.initiated_reset;
    assign o_port_base       = out_res.port_base;
    assign o_port_count      = out_res.port_count;
    assign o_port_states     = out_res.port_states;
    assign o_link_mask       = out_res.link_mask;
    assign o_contender_mask  = out_res.contender_mask;
    assign o_node_count      = out_res.node_count;

endmodule

// ===== rtl/sip_in_stage.sv =====
// Input register of the self-ID packet parser: holds one request.
// Depends on sip_pkg.
module sip_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sip_pkg::t_request i_req,
    input  logic              i_adv,
    output logic              o_ready,
    output logic              o_valid,
    output sip_pkg::t_request o_req
);

    logic              r_valid;
    sip_pkg::t_request r_req;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

// ===== rtl/sip_check.sv =====
// Self-ID quadlet check: map state, packet validation and result forming.
// Depends on sip_pkg.
module sip_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  sip_pkg::t_request i_req,
    output sip_pkg::t_result  o_res
);

    logic [sip_pkg::NODE_W-1:0]    r_next_node;
    logic                          r_more_expected;
    logic [3:0]                    r_more_sequence;
    logic                          r_error_seen;
    logic [sip_pkg::MAX_NODES-1:0] r_link_bits;
    logic [sip_pkg::MAX_NODES-1:0] r_contender_bits;

    logic [sip_pkg::NODE_W-1:0]    n_next_node;
    logic                          n_more_expected;
    logic [3:0]                    n_more_sequence;
    logic                          n_error_seen;
    logic [sip_pkg::MAX_NODES-1:0] n_link_bits;
    logic [sip_pkg::MAX_NODES-1:0] n_contender_bits;

    logic [31:0]                w;
    logic [1:0]                 tag;
    logic [sip_pkg::NODE_W-1:0] id;
    logic [2:0]                 seq;
    logic                       more_flag;
    logic                       more_ok;
    logic                       init_ok;
    logic [sip_pkg::MAX_NODES-1:0] id_bit;

    assign w         = i_req.self_id_word;
    assign tag       = w[sip_pkg::TAG_LO +: 2];
    assign id        = w[sip_pkg::ID_LO +: sip_pkg::NODE_W];
    assign seq       = w[sip_pkg::SEQ_LO +: 3];
    assign more_flag = w[sip_pkg::MORE_BIT];
    assign id_bit    = sip_pkg::MAX_NODES'(1) << id;

    assign more_ok = more_flag && r_more_expected && (r_next_node != '0)
                     && (id == r_next_node - sip_pkg::NODE_W'(1))
                     && ({1'b0, seq} == r_more_sequence);
    assign init_ok = (tag == sip_pkg::SELF_ID_TAG) && !more_flag
                     && (id == r_next_node)
                     && (r_next_node < sip_pkg::NODE_W'(sip_pkg::MAX_NODES));

    always_comb begin
        n_next_node      = r_next_node;
        n_more_expected  = r_more_expected;
        n_more_sequence  = r_more_sequence;
        n_error_seen     = r_error_seen;
        n_link_bits      = r_link_bits;
        n_contender_bits = r_contender_bits;

        o_res                 = '0;
        o_res.node_id         = id;
        o_res.status          = sip_pkg::ST_ERROR;

        if (r_error_seen) begin
            o_res.status = sip_pkg::ST_ERROR;
        end else if (more_ok) begin
            if (seq < 3'(sip_pkg::MORE_PACKETS_USED)) begin
                o_res.status      = sip_pkg::ST_MORE_USED;
                o_res.port_base   = sip_pkg::MORE_PORT_FIRST + {seq[1:0], 3'b000};
                o_res.port_count  = sip_pkg::MORE_PORT_COUNT;
                o_res.port_states = w[19:4];
            end else begin
                o_res.status = sip_pkg::ST_MORE_IGNORED;
            end
            n_more_sequence = r_more_sequence + 4'd1;
            n_more_expected = w[sip_pkg::NEXT_BIT];
        end else if (init_ok) begin
            o_res.status          = sip_pkg::ST_INITIAL;
            o_res.link_active     = w[sip_pkg::LINK_BIT];
            o_res.contender       = w[sip_pkg::CONT_BIT];
            o_res.phy_speed       = w[sip_pkg::SPD_LO +: 2];
            o_res.initiated_reset = w[sip_pkg::IRST_BIT];
            o_res.port_count      = sip_pkg::INIT_PORT_COUNT;
            o_res.port_states     = {10'd0, w[7:2]};
            if (w[sip_pkg::LINK_BIT]) begin
                n_link_bits = r_link_bits | id_bit;
            end
            if (w[sip_pkg::CONT_BIT]) begin
                n_contender_bits = r_contender_bits | id_bit;
            end
            n_next_node     = r_next_node + sip_pkg::NODE_W'(1);
            n_more_expected = w[sip_pkg::NEXT_BIT];
            n_more_sequence = 4'd0;
        end else begin
            n_error_seen = 1'b1;
        end

        o_res.link_mask      = n_link_bits;
        o_res.contender_mask = n_contender_bits;
        o_res.node_count     = n_next_node;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_req.final_word)) begin
            r_next_node      <= '0;
            r_more_expected  <= 1'b0;
            r_more_sequence  <= '0;
            r_error_seen     <= 1'b0;
            r_link_bits      <= '0;
            r_contender_bits <= '0;
        end else if (i_adv) begin
            r_next_node      <= n_next_node;
            r_more_expected  <= n_more_expected;
            r_more_sequence  <= n_more_sequence;
            r_error_seen     <= n_error_seen;
            r_link_bits      <= n_link_bits;
            r_contender_bits <= n_contender_bits;
        end
    end

endmodule

// ===== rtl/sip_out_stage.sv =====
// Result register of the self-ID packet parser.
// Depends on sip_pkg.
module sip_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sip_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output sip_pkg::t_result o_res
);

    logic             r_valid;
    sip_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== tb/sip_map_checker.sv =====
// Result checker for the self-ID packet parser: predicts each result from the
// accepted requests and compares it with what the block returns.
// Depends on sip_pkg.
module sip_map_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_self_id_word,
    input  logic        i_final_word,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_node_id,
    input  logic        i_link_active,
    input  logic        i_contender,
    input  logic [1:0]  i_phy_speed,
    input  logic        i_initiated_reset,
    input  logic [4:0]  i_port_base,
    input  logic [3:0]  i_port_count,
    input  logic [15:0] i_port_states,
    input  logic [62:0] i_link_mask,
    input  logic [62:0] i_contender_mask,
    input  logic [5:0]  i_node_count,
    output int          o_pending,
    output int          o_fail_count
);

    logic [sip_pkg::NODE_W-1:0]    node_next;
    logic                          chain_open;
    logic [3:0]                    chain_len;
    logic                          map_failed;
    logic [sip_pkg::MAX_NODES-1:0] link_bits;
    logic [sip_pkg::MAX_NODES-1:0] contender_bits;

    sip_pkg::t_result expected_q[$];
    sip_pkg::t_result oldest;
    int               fails = 0;

    assign o_pending    = expected_q.size();
    assign o_fail_count = fails;

    function automatic void clear_map();
        node_next      = '0;
        chain_open     = 1'b0;
        chain_len      = '0;
        map_failed     = 1'b0;
        link_bits      = '0;
        contender_bits = '0;
    endfunction

    function automatic sip_pkg::t_result predict_quadlet(input logic [31:0] word,
                                                         input logic last);
        sip_pkg::t_result           r;
        logic [sip_pkg::NODE_W-1:0] id;
        logic [2:0]                 seq;
        r         = '0;
        id        = word[sip_pkg::ID_LO +: sip_pkg::NODE_W];
        seq       = word[sip_pkg::SEQ_LO +: 3];
        r.node_id = id;
        r.status  = sip_pkg::ST_ERROR;
        if (map_failed) begin
            r.status = sip_pkg::ST_ERROR;
        end else if (word[sip_pkg::MORE_BIT] && chain_open && node_next != 0 &&
                     id == node_next - 1 && {1'b0, seq} == chain_len) begin
            if (seq < sip_pkg::MORE_PACKETS_USED) begin
                r.status      = sip_pkg::ST_MORE_USED;
                r.port_base   = sip_pkg::MORE_PORT_FIRST + 5'(8 * seq);
                r.port_count  = sip_pkg::MORE_PORT_COUNT;
                r.port_states = word[19:4];
            end else begin
                r.status = sip_pkg::ST_MORE_IGNORED;
            end
            chain_len  = chain_len + 4'd1;
            chain_open = word[sip_pkg::NEXT_BIT];
        end else if (word[sip_pkg::TAG_LO +: 2] == sip_pkg::SELF_ID_TAG &&
                     !word[sip_pkg::MORE_BIT] &&
                     id == node_next && node_next < sip_pkg::MAX_NODES) begin
            r.status          = sip_pkg::ST_INITIAL;
            r.link_active     = word[sip_pkg::LINK_BIT];
            r.contender       = word[sip_pkg::CONT_BIT];
            r.phy_speed       = word[sip_pkg::SPD_LO +: 2];
            r.initiated_reset = word[sip_pkg::IRST_BIT];
            r.port_count      = sip_pkg::INIT_PORT_COUNT;
            r.port_states     = {10'd0, word[7:2]};
            link_bits[id]      = link_bits[id] | word[sip_pkg::LINK_BIT];
            contender_bits[id] = contender_bits[id] | word[sip_pkg::CONT_BIT];
            node_next  = node_next + 1'b1;
            chain_open = word[sip_pkg::NEXT_BIT];
            chain_len  = '0;
        end else begin
            map_failed = 1'b1;
        end
        r.link_mask      = link_bits;
        r.contender_mask = contender_bits;
        r.node_count     = node_next;
        if (last) begin
            clear_map();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [62:0] want,
                                        input logic [62:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_map();
            expected_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result returned with no request outstanding");
                    fails++;
                end else begin
                    oldest = expected_q.pop_front();
                    check_field("status", oldest.status, i_status);
                    check_field("node_id", oldest.node_id, i_node_id);
                    check_field("link_active", oldest.link_active, i_link_active);
                    check_field("contender", oldest.contender, i_contender);
                    check_field("phy_speed", oldest.phy_speed, i_phy_speed);
                    check_field("initiated_reset", oldest.initiated_reset, i_initiated_reset);
                    check_field("port_base", oldest.port_base, i_port_base);
                    check_field("port_count", oldest.port_count, i_port_count);
                    check_field("port_states", oldest.port_states, i_port_states);
                    check_field("link_mask", oldest.link_mask, i_link_mask);
                    check_field("contender_mask", oldest.contender_mask, i_contender_mask);
                    check_field("node_count", oldest.node_count, i_node_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(predict_quadlet(i_self_id_word, i_final_word));
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the self-ID packet parser testbench: clock, reset, request stimulus
// and the final verdict. Depends on sip_pkg, self_id_packet_parser_top and
// sip_map_checker.
module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 950;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_self_id_word;
    logic        i_final_word;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [1:0]  o_status;
    logic [5:0]  o_node_id;
    logic        o_link_active;
    logic        o_contender;
    logic [1:0]  o_phy_speed;
    logic        o_initiated_reset;
    logic [4:0]  o_port_base;
    logic [3:0]  o_port_count;
    logic [15:0] o_port_states;
    logic [62:0] o_link_mask;
    logic [62:0] o_contender_mask;
    logic [5:0]  o_node_count;

    int pending;
    int fail_count;
    int sent = 0;
    int send_idle_pct = 14;
    int recv_stall_pct = 14;
    int idle_cycles;
    int map_no;
    int k;

    always #10 i_clk = ~i_clk;

    self_id_packet_parser_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_self_id_word    (i_self_id_word),
        .i_final_word      (i_final_word),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_status          (o_status),
        .o_node_id         (o_node_id),
        .o_link_active     (o_link_active),
        .o_contender       (o_contender),
        .o_phy_speed       (o_phy_speed),
        .o_initiated_reset (o_initiated_reset),
        .o_port_base       (o_port_base),
        .o_port_count      (o_port_count),
        .o_port_states     (o_port_states),
        .o_link_mask       (o_link_mask),
        .o_contender_mask  (o_contender_mask),
        .o_node_count      (o_node_count)
    );

    sip_map_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_self_id_word    (i_self_id_word),
        .i_final_word      (i_final_word),
        .i_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .i_status          (o_status),
        .i_node_id         (o_node_id),
        .i_link_active     (o_link_active),
        .i_contender       (o_contender),
        .i_phy_speed       (o_phy_speed),
        .i_initiated_reset (o_initiated_reset),
        .i_port_base       (o_port_base),
        .i_port_count      (o_port_count),
        .i_port_states     (o_port_states),
        .i_link_mask       (o_link_mask),
        .i_contender_mask  (o_contender_mask),
        .i_node_count      (o_node_count),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    function automatic logic [31:0] initial_quadlet(input logic [5:0] id,
                                                    input logic [31:0] fill,
                                                    input logic more);
        logic [31:0] w;
        w                                    = fill;
        w[sip_pkg::TAG_LO +: 2]              = sip_pkg::SELF_ID_TAG;
        w[sip_pkg::ID_LO +: sip_pkg::NODE_W] = id;
        w[sip_pkg::MORE_BIT]                 = 1'b0;
        w[sip_pkg::NEXT_BIT]                 = more;
        return w;
    endfunction

    function automatic logic [31:0] more_quadlet(input logic [5:0] id, input int seq,
                                                 input logic [31:0] fill,
                                                 input logic more);
        logic [31:0] w;
        w                                    = fill;
        w[sip_pkg::ID_LO +: sip_pkg::NODE_W] = id;
        w[sip_pkg::MORE_BIT]                 = 1'b1;
        w[sip_pkg::SEQ_LO +: 3]              = 3'(seq);
        w[sip_pkg::NEXT_BIT]                 = more;
        return w;
    endfunction

    task automatic send_quadlet(input logic [31:0] word, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_self_id_word <= word;
        i_final_word   <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_map(input int nodes, input logic noisy);
        int          conts;
        int          n;
        int          s;
        logic [31:0] word;
        logic        last;
        for (n = 0; n < nodes; n++) begin
            conts = ($urandom_range(9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
            for (s = 0; s <= conts; s++) begin
                if (s == 0) begin
                    word = initial_quadlet(6'(n), $urandom, conts != 0);
                end else begin
                    word = more_quadlet(6'(n), s - 1, $urandom, s != conts);
                end
                if (noisy && $urandom_range(99) < 4) begin
                    case ($urandom_range(2))
                        0: word = $urandom;
                        1: word[$urandom_range(31, 20)] ^= 1'b1;
                        default: word[sip_pkg::NEXT_BIT] ^= 1'b1;
                    endcase
                end
                last = (n == nodes - 1 && s == conts) || (noisy && $urandom_range(199) == 0);
                send_quadlet(word, last);
                if (last) begin
                    return;
                end
            end
        end
    endtask

    initial begin
        i_res_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_res_valid && i_res_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_self_id_word = '0;
        i_final_word   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full chain: used continuations, then ignored ones, then a broken chain
        send_quadlet(initial_quadlet(6'd0, '1, 1'b1), 1'b0);
        send_quadlet(more_quadlet(6'd0, 0, '1, 1'b1), 1'b0);
        send_quadlet(more_quadlet(6'd0, 1, '0, 1'b1), 1'b0);
        send_quadlet(more_quadlet(6'd0, 2, $urandom, 1'b1), 1'b0);
        send_quadlet(more_quadlet(6'd0, 3, $urandom, 1'b1), 1'b0);
        send_quadlet(more_quadlet(6'd0, 4, $urandom, 1'b0), 1'b0);
        send_quadlet(initial_quadlet(6'd1, '0, 1'b0), 1'b0);
        send_quadlet(more_quadlet(6'd1, 0, $urandom, 1'b0), 1'b0);
        send_quadlet(initial_quadlet(6'd2, $urandom, 1'b0), 1'b1);
        // bad tag, then an id out of order
        send_quadlet(initial_quadlet(6'd0, '0, 1'b0) | (32'd1 << sip_pkg::TAG_LO), 1'b1);
        send_quadlet(initial_quadlet(6'd1, $urandom, 1'b0), 1'b1);
        // run the continuation count past its last sequence number
        send_quadlet(initial_quadlet(6'd0, $urandom, 1'b1), 1'b0);
        for (k = 0; k < 9; k++) begin
            send_quadlet(more_quadlet(6'd0, k, $urandom, 1'b1), k == 8);
        end
        wait_drained();

        map_no = 0;
        while (sent < 21 + RANDOM_ITEMS) begin
            if (map_no == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (map_no == 14) begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
            if (map_no == 20) begin
                wait_drained();
            end
            if (map_no == 3) begin
                send_map(sip_pkg::MAX_NODES + 1, 1'b0);
            end else if ($urandom_range(39) == 0) begin
                send_map(sip_pkg::MAX_NODES, 1'b1);
            end else begin
                send_map($urandom_range(1, 8), 1'b1);
            end
            map_no++;
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
